// ===== hdl/tica_pkg.sv =====
// ----------------------------------------------------------------------------
// tica_pkg
// Types, codes and type-table functions for the typed integer constant ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package tica_pkg;

  localparam logic [1:0] KIND_BIN  = 2'd0;
  localparam logic [1:0] KIND_UN   = 2'd1;
  localparam logic [1:0] KIND_CONV = 2'd2;

  localparam logic [3:0] OP_MUL = 4'd0;
  localparam logic [3:0] OP_DIV = 4'd1;
  localparam logic [3:0] OP_MOD = 4'd2;
  localparam logic [3:0] OP_ADD = 4'd3;
  localparam logic [3:0] OP_SUB = 4'd4;
  localparam logic [3:0] OP_AND = 4'd5;
  localparam logic [3:0] OP_XOR = 4'd6;
  localparam logic [3:0] OP_OR  = 4'd7;
  localparam logic [3:0] OP_LT  = 4'd8;
  localparam logic [3:0] OP_GT  = 4'd9;
  localparam logic [3:0] OP_LE  = 4'd10;
  localparam logic [3:0] OP_GE  = 4'd11;
  localparam logic [3:0] OP_EQ  = 4'd12;
  localparam logic [3:0] OP_NE  = 4'd13;
  localparam logic [3:0] OP_SHL = 4'd14;
  localparam logic [3:0] OP_SHR = 4'd15;

  localparam logic [3:0] UOP_PLUS  = 4'd0;
  localparam logic [3:0] UOP_NEG   = 4'd1;
  localparam logic [3:0] UOP_COMPL = 4'd2;
  localparam logic [3:0] UOP_LNOT  = 4'd3;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_DIVZ  = 3'd1;
  localparam logic [2:0] ERR_SHNEG = 3'd2;
  localparam logic [2:0] ERR_SHBIG = 3'd3;
  localparam logic [2:0] ERR_UNSUP = 3'd4;

  localparam logic [4:0] T_BOOL  = 5'd0;
  localparam logic [4:0] T_INT   = 5'd9;
  localparam logic [4:0] T_UINT  = 5'd10;
  localparam logic [4:0] T_LONG  = 5'd11;
  localparam logic [4:0] T_ULONG = 5'd12;
  localparam logic [4:0] T_LL    = 5'd13;
  localparam logic [4:0] T_ULL   = 5'd14;
  localparam logic [4:0] T_I128  = 5'd15;
  localparam logic [4:0] T_U128  = 5'd16;
  localparam logic [4:0] T_LAST  = 5'd16;

  localparam int MUL_STEPS = 10;
  localparam int DIV_STEPS = 128;
  localparam int MUL_LIMB_A [MUL_STEPS] = '{0, 0, 1, 0, 1, 2, 0, 1, 2, 3};
  localparam int MUL_LIMB_B [MUL_STEPS] = '{0, 1, 0, 2, 1, 0, 3, 2, 1, 0};

  typedef enum logic [1:0] {
    SEL_ACC,
    SEL_QUO,
    SEL_REM
  } sel_e;

  typedef struct packed {
    logic [4:0] rtype;
    logic [2:0] err;
    sel_e       sel;
    logic       mul;
    logic       neg_q;
    logic       neg_r;
  } ctl_t;

  typedef struct packed {
    ctl_t         ctl;
    logic [127:0] opa;
    logic [127:0] opb;
    logic [127:0] acc;
    logic [127:0] rem;
  } lane_t;

  function automatic logic [7:0] type_wid(logic [4:0] t);
    logic [7:0] w;
    w = 8'd128;
    if (t inside {[5'd0:5'd3]}) w = 8'd8;
    else if (t inside {[5'd4:5'd6]}) w = 8'd16;
    else if (t inside {[5'd7:5'd10]}) w = 8'd32;
    else if (t inside {[5'd11:5'd14]}) w = 8'd64;
    return w;
  endfunction

  function automatic logic type_sgn(logic [4:0] t);
    return t inside {5'd1, 5'd2, 5'd4, 5'd7, 5'd9, 5'd11, 5'd13, 5'd15};
  endfunction

  function automatic logic [4:0] type_prom(logic [4:0] t);
    logic [4:0] p;
    p = t;
    if (t inside {[5'd0:5'd7], T_INT}) p = T_INT;
    else if (t inside {5'd8, T_UINT}) p = T_UINT;
    return p;
  endfunction

  function automatic logic [2:0] type_rank(logic [4:0] t);
    logic [2:0] r;
    r = 3'd1;
    if (t inside {T_LONG, T_ULONG}) r = 3'd2;
    else if (t inside {T_LL, T_ULL}) r = 3'd3;
    else if (t inside {T_I128, T_U128}) r = 3'd4;
    return r;
  endfunction

  function automatic logic [4:0] signed_of(logic [2:0] r);
    logic [4:0] t;
    case (r)
      3'd2:    t = T_LONG;
      3'd3:    t = T_LL;
      3'd4:    t = T_I128;
      default: t = T_INT;
    endcase
    return t;
  endfunction

  function automatic logic [4:0] unsigned_of(logic [2:0] r);
    logic [4:0] t;
    case (r)
      3'd2:    t = T_ULONG;
      3'd3:    t = T_ULL;
      3'd4:    t = T_U128;
      default: t = T_UINT;
    endcase
    return t;
  endfunction

  function automatic logic [4:0] common_type(logic [4:0] a, logic [4:0] b);
    logic       as;
    logic       bs;
    logic [2:0] ar;
    logic [2:0] br;
    logic [2:0] sr;
    logic [2:0] ur;
    logic [4:0] c;
    as = type_sgn(a);
    bs = type_sgn(b);
    ar = type_rank(a);
    br = type_rank(b);
    sr = as ? ar : br;
    ur = as ? br : ar;
    if (a == b) begin
      c = a;
    end else if (as == bs) begin
      c = as ? signed_of((ar >= br) ? ar : br) : unsigned_of((ar >= br) ? ar : br);
    end else if (ur >= sr) begin
      c = unsigned_of(ur);
    end else if (type_wid(signed_of(sr)) > type_wid(unsigned_of(ur))) begin
      c = signed_of(sr);
    end else begin
      c = unsigned_of(sr);
    end
    return c;
  endfunction

  function automatic logic [127:0] norm_val(logic [4:0] t, logic [127:0] v);
    logic         s;
    logic [127:0] r;
    s = type_sgn(t);
    case (type_wid(t))
      8'd8:    r = s ? {{120{v[7]}}, v[7:0]} : {120'd0, v[7:0]};
      8'd16:   r = s ? {{112{v[15]}}, v[15:0]} : {112'd0, v[15:0]};
      8'd32:   r = s ? {{96{v[31]}}, v[31:0]} : {96'd0, v[31:0]};
      8'd64:   r = s ? {{64{v[63]}}, v[63:0]} : {64'd0, v[63:0]};
      default: r = v;
    endcase
    if (t == T_BOOL) r = {127'd0, |v};
    return r;
  endfunction

  function automatic logic [127:0] read_op(logic [4:0] t, logic [63:0] lo, logic [63:0] hi);
    return norm_val(t, (type_wid(t) <= 8'd64) ? {64'd0, lo} : {hi, lo});
  endfunction

endpackage

`default_nettype wire

// ===== hdl/typed_integer_constant_alu.sv =====
// ----------------------------------------------------------------------------
// typed_integer_constant_alu
// C integer operator unit with promotion and usual arithmetic conversions.
// ----------------------------------------------------------------------------
// pipeline: 141 register stages from the accepting edge to result valid
//   (2 front, 10 multiply cells, 128 divide cells, output)
// throughput: one transaction per cycle; the whole chain holds while a
//   result waits on out_ready_i
// reset: rst_ni clears all valid flags asynchronously; no other state
`default_nettype none

module typed_integer_constant_alu (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [3:0]  op_i,
  input  wire logic [4:0]  lhs_type_i,
  input  wire logic [63:0] lhs_lo_i,
  input  wire logic [63:0] lhs_hi_i,
  input  wire logic [4:0]  rhs_type_i,
  input  wire logic [63:0] rhs_lo_i,
  input  wire logic [63:0] rhs_hi_i,
  input  wire logic [4:0]  target_type_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       result_type_o,
  output logic [63:0]      result_lo_o,
  output logic [63:0]      result_hi_o,
  output logic [2:0]       error_o
);
  import tica_pkg::*;

  logic  en;
  logic  mul_vld [MUL_STEPS+1];
  lane_t mul_lane [MUL_STEPS+1];
  logic  div_vld [DIV_STEPS+1];
  lane_t div_lane [DIV_STEPS+1];

  assign en         = ~out_valid_o | out_ready_i;
  assign in_ready_o = en;

  tica_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_valid_i),
    .kind_i        (kind_i),
    .op_i          (op_i),
    .lhs_type_i    (lhs_type_i),
    .lhs_lo_i      (lhs_lo_i),
    .lhs_hi_i      (lhs_hi_i),
    .rhs_type_i    (rhs_type_i),
    .rhs_lo_i      (rhs_lo_i),
    .rhs_hi_i      (rhs_hi_i),
    .target_type_i (target_type_i),
    .valid_o       (mul_vld[0]),
    .lane_o        (mul_lane[0])
  );

  for (genvar g = 0; g < MUL_STEPS; g++) begin : g_mul
    tica_mul_cell #(
      .LimbA (MUL_LIMB_A[g]),
      .LimbB (MUL_LIMB_B[g])
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (mul_vld[g]),
      .lane_i  (mul_lane[g]),
      .valid_o (mul_vld[g+1]),
      .lane_o  (mul_lane[g+1])
    );
  end

  always_comb begin
    div_vld[0]      = mul_vld[MUL_STEPS];
    div_lane[0]     = mul_lane[MUL_STEPS];
    div_lane[0].rem = '0;
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    tica_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_vld[g]),
      .lane_i  (div_lane[g]),
      .valid_o (div_vld[g+1]),
      .lane_o  (div_lane[g+1])
    );
  end

  tica_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (div_vld[DIV_STEPS]),
    .lane_i        (div_lane[DIV_STEPS]),
    .valid_o       (out_valid_o),
    .result_type_o (result_type_o),
    .result_lo_o   (result_lo_o),
    .result_hi_o   (result_hi_o),
    .error_o       (error_o)
  );

endmodule

`default_nettype wire

// ===== hdl/tica_front.sv =====
// ----------------------------------------------------------------------------
// tica_front
// Two-stage operand front end: type decode, promotion, conversion and the
// add, logic, compare, shift and unary operators; sets up the multiply and divide lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module tica_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [1:0]     kind_i,
  input  wire logic [3:0]     op_i,
  input  wire logic [4:0]     lhs_type_i,
  input  wire logic [63:0]    lhs_lo_i,
  input  wire logic [63:0]    lhs_hi_i,
  input  wire logic [4:0]     rhs_type_i,
  input  wire logic [63:0]    rhs_lo_i,
  input  wire logic [63:0]    rhs_hi_i,
  input  wire logic [4:0]     target_type_i,
  output logic                valid_o,
  output tica_pkg::lane_t     lane_o
);
  import tica_pkg::*;

  logic         v1_q;
  logic [1:0]   kind_q;
  logic [3:0]   op_q;
  logic         unsup_q;
  logic [127:0] a_q, a_d;
  logic [127:0] b_q, b_d;
  logic [4:0]   rtype_q, rtype_d;
  logic         sgn_q, sgn_d;
  logic         csgn_q, csgn_d;
  logic [7:0]   w_q, w_d;
  logic         unsup_d;

  logic [127:0] l;
  logic [127:0] r;
  logic [4:0]   pl;
  logic [4:0]   pr;
  logic [4:0]   c;

  always_comb begin
    l  = read_op(lhs_type_i, lhs_lo_i, lhs_hi_i);
    r  = read_op(rhs_type_i, rhs_lo_i, rhs_hi_i);
    pl = type_prom(lhs_type_i);
    pr = type_prom(rhs_type_i);
    c  = common_type(pl, pr);
    unsup_d = (kind_i == 2'd3) || (lhs_type_i > T_LAST)
           || ((kind_i == KIND_BIN) && (rhs_type_i > T_LAST))
           || ((kind_i == KIND_CONV) && (target_type_i > T_LAST))
           || ((kind_i == KIND_UN) && (op_i > UOP_LNOT));
    a_d     = norm_val(c, l);
    b_d     = norm_val(c, r);
    rtype_d = c;
    sgn_d   = type_sgn(c);
    csgn_d  = type_sgn(pr);
    w_d     = type_wid(pl);
    if (kind_i == KIND_CONV) begin
      a_d     = norm_val(target_type_i, l);
      rtype_d = target_type_i;
    end else if (kind_i == KIND_UN) begin
      if (op_i == UOP_LNOT) begin
        a_d     = {127'd0, ~|l};
        rtype_d = T_BOOL;
      end else begin
        a_d     = norm_val(pl, l);
        rtype_d = pl;
      end
    end else if (op_i == OP_SHL || op_i == OP_SHR) begin
      a_d     = norm_val(pl, l);
      b_d     = norm_val(pr, r);
      rtype_d = pl;
      sgn_d   = type_sgn(pl);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q  <= kind_i;
      op_q    <= op_i;
      unsup_q <= unsup_d;
      a_q     <= a_d;
      b_q     <= b_d;
      rtype_q <= rtype_d;
      sgn_q   <= sgn_d;
      csgn_q  <= csgn_d;
      w_q     <= w_d;
    end
  end

  lane_t        lane_d;
  logic         slt;
  logic         ult;
  logic         a_neg;
  logic         b_neg;

  always_comb begin
    slt   = $signed(a_q) < $signed(b_q);
    ult   = a_q < b_q;
    a_neg = sgn_q & a_q[127];
    b_neg = sgn_q & b_q[127];
    lane_d = '0;
    lane_d.ctl.rtype = rtype_q;
    lane_d.ctl.err   = ERR_NONE;
    lane_d.ctl.sel   = SEL_ACC;
    lane_d.acc       = a_q;
    if (kind_q == KIND_UN) begin
      case (op_q)
        UOP_NEG:   lane_d.acc = -a_q;
        UOP_COMPL: lane_d.acc = ~a_q;
        default:   lane_d.acc = a_q;
      endcase
    end else if (kind_q == KIND_BIN) begin
      case (op_q)
        OP_MUL: begin
          lane_d.ctl.mul = 1'b1;
          lane_d.opa     = a_q;
          lane_d.opb     = b_q;
          lane_d.acc     = '0;
        end
        OP_DIV, OP_MOD: begin
          lane_d.ctl.sel   = (op_q == OP_DIV) ? SEL_QUO : SEL_REM;
          lane_d.ctl.neg_q = a_neg ^ b_neg;
          lane_d.ctl.neg_r = a_neg;
          lane_d.opa       = a_neg ? -a_q : a_q;
          lane_d.opb       = b_neg ? -b_q : b_q;
          if (b_q == '0) lane_d.ctl.err = ERR_DIVZ;
        end
        OP_ADD: lane_d.acc = a_q + b_q;
        OP_SUB: lane_d.acc = a_q - b_q;
        OP_AND: lane_d.acc = a_q & b_q;
        OP_XOR: lane_d.acc = a_q ^ b_q;
        OP_OR:  lane_d.acc = a_q | b_q;
        OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ, OP_NE: begin
          lane_d.ctl.rtype = T_BOOL;
          case (op_q)
            OP_LT:   lane_d.acc = {127'd0, sgn_q ? slt : ult};
            OP_GE:   lane_d.acc = {127'd0, ~(sgn_q ? slt : ult)};
            OP_GT:   lane_d.acc = {127'd0, sgn_q ? ($signed(b_q) < $signed(a_q)) : (b_q < a_q)};
            OP_LE:   lane_d.acc = {127'd0, ~(sgn_q ? ($signed(b_q) < $signed(a_q)) : (b_q < a_q))};
            OP_EQ:   lane_d.acc = {127'd0, a_q == b_q};
            default: lane_d.acc = {127'd0, a_q != b_q};
          endcase
        end
        default: begin
          if (op_q == OP_SHL) lane_d.acc = a_q << b_q[6:0];
          else if (sgn_q) lane_d.acc = $signed(a_q) >>> b_q[6:0];
          else lane_d.acc = a_q >> b_q[6:0];
          if (csgn_q && b_q[127]) lane_d.ctl.err = ERR_SHNEG;
          else if (b_q[127:64] != '0 || b_q[63:0] >= {56'd0, w_q}) lane_d.ctl.err = ERR_SHBIG;
        end
      endcase
    end
    if (unsup_q) lane_d.ctl.err = ERR_UNSUP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_o <= lane_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tica_mul_cell.sv =====
// ----------------------------------------------------------------------------
// tica_mul_cell
// One multiply cell: adds one 32x32 limb product into the running product of a multiply lane.
// ----------------------------------------------------------------------------
`default_nettype none

module tica_mul_cell #(
  parameter int LimbA = 0,
  parameter int LimbB = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  tica_pkg::lane_t     lane_i,
  output logic                valid_o,
  output tica_pkg::lane_t     lane_o
);
  import tica_pkg::*;

  localparam int Shift = 32 * (LimbA + LimbB);

  logic [63:0] prod;
  lane_t       lane_d;

  always_comb begin
    prod   = lane_i.opa[32*LimbA +: 32] * lane_i.opb[32*LimbB +: 32];
    lane_d = lane_i;
    if (lane_i.ctl.mul) lane_d.acc = lane_i.acc + ({64'd0, prod} << Shift);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_o <= lane_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tica_div_cell.sv =====
// ----------------------------------------------------------------------------
// tica_div_cell
// One restoring divide cell: shifts in one dividend bit, produces one
// quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module tica_div_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  tica_pkg::lane_t     lane_i,
  output logic                valid_o,
  output tica_pkg::lane_t     lane_o
);
  import tica_pkg::*;

  logic [128:0] trial;
  logic [128:0] diff;
  logic         ge;
  lane_t        lane_d;

  always_comb begin
    trial  = {lane_i.rem, lane_i.opa[127]};
    diff   = trial - {1'b0, lane_i.opb};
    ge     = trial >= {1'b0, lane_i.opb};
    lane_d = lane_i;
    lane_d.rem = ge ? diff[127:0] : trial[127:0];
    lane_d.opa = {lane_i.opa[126:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_o <= lane_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tica_back.sv =====
// ----------------------------------------------------------------------------
// tica_back
// Result select, sign fixup, normalization to the result type, zeroing of
// error results, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tica_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  tica_pkg::lane_t     lane_i,
  output logic                valid_o,
  output logic [4:0]          result_type_o,
  output logic [63:0]         result_lo_o,
  output logic [63:0]         result_hi_o,
  output logic [2:0]          error_o
);
  import tica_pkg::*;

  logic [127:0] raw;
  logic [127:0] val;
  logic [4:0]   typ;

  always_comb begin
    case (lane_i.ctl.sel)
      SEL_QUO: raw = lane_i.ctl.neg_q ? -lane_i.opa : lane_i.opa;
      SEL_REM: raw = lane_i.ctl.neg_r ? -lane_i.rem : lane_i.rem;
      default: raw = lane_i.acc;
    endcase
    typ = lane_i.ctl.rtype;
    val = norm_val(typ, raw);
    if (lane_i.ctl.err != ERR_NONE) begin
      typ = T_BOOL;
      val = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_type_o <= typ;
      result_lo_o   <= val[63:0];
      result_hi_o   <= (type_wid(typ) > 8'd64) ? val[127:64] : 64'd0;
      error_o       <= lane_i.ctl.err;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tica_checker.sv =====
// ----------------------------------------------------------------------------
// tica_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tica_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [4:0]  result_type_o,
  input wire logic [63:0] result_lo_o,
  input wire logic [63:0] result_hi_o,
  input wire logic [2:0]  error_o
);
  import tica_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_lo_o)
      && $stable(result_hi_o) && $stable(error_o) && $stable(result_type_o))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o != ERR_NONE |-> result_type_o == T_BOOL
      && result_lo_o == 64'd0 && result_hi_o == 64'd0)
    else $error("error result carries data");

  a_hi_wide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_hi_o != 64'd0 |-> result_type_o == T_I128
      || result_type_o == T_U128)
    else $error("high half set for narrow type");

  a_bool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_type_o == T_BOOL |-> result_lo_o[63:1] == 63'd0)
    else $error("bool result out of range");

endmodule

bind typed_integer_constant_alu tica_checker u_tica_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_type_o (result_type_o),
  .result_lo_o   (result_lo_o),
  .result_hi_o   (result_hi_o),
  .error_o       (error_o)
);

`default_nettype wire
